### src/gb3_pkg.sv
`default_nettype none

package gb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = CH_W + 4;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
  // The row counter runs one past the frame height while the last row drains.
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

  localparam int REG_FRAME_WIDTH  = 0;
  localparam int REG_FRAME_HEIGHT = 1;

  typedef logic [CH_W-1:0]      chan_t;
  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [2*PIX_W-1:0]   line_word_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [WCNT_W-1:0]    wcnt_t;
  typedef logic [HCNT_W-1:0]    hcnt_t;
  typedef logic [SUM_W-1:0]     sum_t;

  // Window taps, indexed [row][column]; row 2 is the newest row, column 2 the newest column.
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic top_clamp;
    logic left_clamp;
    logic right_clamp;
  } tap_ctrl_t;

endpackage

`default_nettype wire

### src/gb3_if.sv
`default_nettype none

interface gb3_pix_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  gb3_pkg::chan_t       red_in;
  gb3_pkg::chan_t       green_in;
  gb3_pkg::chan_t       blue_in;

  modport source (output valid, output mode, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink (input valid, input mode, input red_in, input green_in,
                input blue_in, output ready);
endinterface

interface gb3_pix_out_if;
  logic                 valid;
  logic                 ready;
  gb3_pkg::chan_t       red_out;
  gb3_pkg::chan_t       green_out;
  gb3_pkg::chan_t       blue_out;
  logic                 frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_end, output ready);
endinterface

interface gb3_cfg_if;
  logic                 valid;
  logic                 ready;
  gb3_pkg::cfg_idx_t    index;
  gb3_pkg::dim_t        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/gb3_ram.sv
`default_nettype none

module gb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/gb3_blur.sv
`default_nettype none

module gb3_blur (
  input  wire gb3_pkg::window_t   wnd,
  input  wire gb3_pkg::tap_ctrl_t ctl,
  output gb3_pkg::pix_t           result
);

  gb3_pkg::window_t taps;

  // Clamp at the frame edges by repeating the center row or column.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (r == 0 && ctl.top_clamp) begin
        taps[r] = wnd[1];
      end else begin
        taps[r] = wnd[r];
      end
    end
    for (int r = 0; r < 3; r++) begin
      if (ctl.left_clamp) begin
        taps[r][0] = taps[r][1];
      end
      if (ctl.right_clamp) begin
        taps[r][2] = taps[r][1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_chan
    gb3_pkg::sum_t row_sum [3];
    gb3_pkg::sum_t total;

    always_comb begin
      for (int r = 0; r < 3; r++) begin
        row_sum[r] = gb3_pkg::sum_t'(taps[r][0][k*gb3_pkg::CH_W +: gb3_pkg::CH_W])
                   + (gb3_pkg::sum_t'(taps[r][1][k*gb3_pkg::CH_W +: gb3_pkg::CH_W]) << 1)
                   + gb3_pkg::sum_t'(taps[r][2][k*gb3_pkg::CH_W +: gb3_pkg::CH_W]);
      end
      total = row_sum[0] + (row_sum[1] << 1) + row_sum[2];
    end

    assign result[k*gb3_pkg::CH_W +: gb3_pkg::CH_W] = total[gb3_pkg::SUM_W-1 -: gb3_pkg::CH_W];
  end

endmodule

`default_nettype wire

### src/gaussian_blur_3x3_rgb.sv
`default_nettype none

// 3x3 Gaussian blur (1-2-1 kernel in both directions) on an RGB pixel stream.
// pix_in takes pixels of one frame in raster order (mode 0), then drain items
// (mode 1) that flush the last row; a drain sent before the frame is complete, or
// a pixel sent while the flush is pending, is taken and dropped. pix_out carries
// one blurred pixel per result, with frame_end set on the last pixel of the frame.
// Frame edges are clamped, so every pixel of the frame is filtered.
// Result k belongs to the transaction that carries input position k+width+1, and
// frame_width+1 drain items follow the last pixel.
// That result moves through the read and window stages into the pix_out register.
// Throughput is one transaction per cycle: each item does one read and one write
// of the line memory, which holds both previous rows side by side at one address.
// The cfg channel is always ready; a write to frame_width (index 0) or
// frame_height (index 1) restarts the frame; values are clamped to 1..1024.
// Reset restarts the frame at 1024 x 1024; the line memory needs no clearing.
// When pix_out is stalled with a result held, the whole pipeline holds and
// pix_in.ready drops until the held result is taken.
module gaussian_blur_3x3_rgb (
  input wire logic  clk,
  input wire logic  rst,
  gb3_pix_in_if.sink    pix_in,
  gb3_pix_out_if.source pix_out,
  gb3_cfg_if.sink       cfg
);

  gb3_pkg::wcnt_t w_eff;
  gb3_pkg::hcnt_t h_eff;
  gb3_pkg::wcnt_t w_new;
  gb3_pkg::hcnt_t h_new;
  gb3_pkg::col_t  col_cnt;
  gb3_pkg::row_t  row_cnt;
  gb3_pkg::col_t  col_cnt_next;
  gb3_pkg::row_t  row_cnt_next;
  gb3_pkg::wcnt_t col_inc;

  logic stall;
  logic cfg_take;
  logic in_take;
  logic proceed;
  logic input_done;
  logic emit_now;
  logic last_now;
  gb3_pkg::tap_ctrl_t ctl_now;

  // Read stage.
  logic               s1_valid;
  logic               s1_drain;
  logic               s1_emit;
  logic               s1_last;
  gb3_pkg::tap_ctrl_t s1_ctl;
  gb3_pkg::pix_t      s1_pix;
  gb3_pkg::col_t      s1_addr;
  logic               fwd_hit;
  gb3_pkg::line_word_t fwd_data;

  gb3_pkg::line_word_t rd_data;
  gb3_pkg::line_word_t line_word;
  gb3_pkg::pix_t       old_up;
  gb3_pkg::pix_t       old_mid;
  gb3_pkg::pix_t       new_pix;
  gb3_pkg::line_word_t wr_data;
  logic                wr_en;

  // Window stage.
  gb3_pkg::window_t    wnd;
  logic                s2_emit;
  logic                s2_last;
  gb3_pkg::tap_ctrl_t  s2_ctl;
  gb3_pkg::pix_t       blur_pix;
  logic                out_load;

  assign cfg.ready = 1'b1;
  assign cfg_take  = cfg.valid;

  assign stall        = s2_emit && pix_out.valid && !pix_out.ready;
  assign pix_in.ready = !stall;
  assign in_take      = pix_in.valid && !stall;

  always_comb begin
    if (cfg.data == '0) begin
      w_new = gb3_pkg::wcnt_t'(1);
      h_new = gb3_pkg::hcnt_t'(1);
    end else begin
      w_new = (32'(cfg.data) > 32'(gb3_pkg::MAX_WIDTH))
            ? gb3_pkg::wcnt_t'(gb3_pkg::MAX_WIDTH) : gb3_pkg::wcnt_t'(cfg.data);
      h_new = (32'(cfg.data) > 32'(gb3_pkg::MAX_HEIGHT))
            ? gb3_pkg::hcnt_t'(gb3_pkg::MAX_HEIGHT) : gb3_pkg::hcnt_t'(cfg.data);
    end
  end

  // Position bookkeeping is done at acceptance, ahead of the memory read.
  always_comb begin
    input_done = 32'(row_cnt) >= 32'(h_eff);
    proceed    = in_take && (pix_in.mode == input_done);
    emit_now   = (32'(row_cnt) >= 32'd2) || (32'(row_cnt) == 32'd1 && col_cnt != '0);
    last_now   = (32'(row_cnt) == 32'(h_eff) + 32'd1) && (col_cnt == '0);
    if (col_cnt != '0) begin
      ctl_now.top_clamp   = 32'(row_cnt) < 32'd2;
      ctl_now.left_clamp  = 32'(col_cnt) < 32'd2;
      ctl_now.right_clamp = 1'b0;
    end else begin
      // Center is the last column two rows up.
      ctl_now.top_clamp   = 32'(row_cnt) < 32'd3;
      ctl_now.left_clamp  = w_eff < gb3_pkg::wcnt_t'(2);
      ctl_now.right_clamp = 1'b1;
    end
    col_inc      = gb3_pkg::wcnt_t'(col_cnt) + gb3_pkg::wcnt_t'(1);
    col_cnt_next = col_cnt;
    row_cnt_next = row_cnt;
    if (last_now) begin
      col_cnt_next = '0;
      row_cnt_next = '0;
    end else if (col_inc >= w_eff) begin
      col_cnt_next = '0;
      row_cnt_next = row_cnt + gb3_pkg::row_t'(1);
    end else begin
      col_cnt_next = gb3_pkg::col_t'(col_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff   <= gb3_pkg::wcnt_t'(gb3_pkg::MAX_WIDTH);
      h_eff   <= gb3_pkg::hcnt_t'(gb3_pkg::MAX_HEIGHT);
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cfg_take) begin
      if (32'(cfg.index) == gb3_pkg::REG_FRAME_WIDTH) begin
        w_eff   <= w_new;
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (32'(cfg.index) == gb3_pkg::REG_FRAME_HEIGHT) begin
        h_eff   <= h_new;
        col_cnt <= '0;
        row_cnt <= '0;
      end
    end else if (proceed) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // Line memory: upper row in the high half, middle row in the low half.
  gb3_ram #(
    .WIDTH (2 * gb3_pkg::PIX_W),
    .DEPTH (gb3_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (wr_data),
    .rd_en   (proceed),
    .rd_addr (col_cnt),
    .rd_data (rd_data)
  );

  always_comb begin
    line_word = fwd_hit ? fwd_data : rd_data;
    old_up    = line_word[2*gb3_pkg::PIX_W-1 -: gb3_pkg::PIX_W];
    old_mid   = line_word[gb3_pkg::PIX_W-1:0];
    // A drain item repeats the last real row at the bottom edge.
    new_pix   = s1_drain ? old_mid : s1_pix;
    wr_data   = {old_mid, new_pix};
    wr_en     = s1_valid && !stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (!stall) begin
      s1_valid <= proceed;
      // The write of the item ahead lands in the same cycle as this read.
      fwd_hit  <= proceed && wr_en && (s1_addr == col_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      s1_drain <= pix_in.mode;
      s1_emit  <= emit_now;
      s1_last  <= last_now;
      s1_ctl   <= ctl_now;
      s1_pix   <= {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
      s1_addr  <= col_cnt;
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wnd     <= '0;
      s2_emit <= 1'b0;
    end else if (!stall) begin
      s2_emit <= s1_valid && s1_emit;
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          wnd[r][0] <= wnd[r][1];
          wnd[r][1] <= wnd[r][2];
        end
        wnd[0][2] <= old_up;
        wnd[1][2] <= old_mid;
        wnd[2][2] <= new_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_last <= s1_last;
      s2_ctl  <= s1_ctl;
    end
  end

  gb3_blur u_blur (
    .wnd    (wnd),
    .ctl    (s2_ctl),
    .result (blur_pix)
  );

  assign out_load = s2_emit && (!pix_out.valid || pix_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (out_load) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pix_out.red_out   <= blur_pix[3*gb3_pkg::CH_W-1 -: gb3_pkg::CH_W];
      pix_out.green_out <= blur_pix[2*gb3_pkg::CH_W-1 -: gb3_pkg::CH_W];
      pix_out.blue_out  <= blur_pix[gb3_pkg::CH_W-1:0];
      pix_out.frame_end <= s2_last;
    end
  end

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    gb3_pkg::wcnt_t'(col_cnt) < w_eff)
    else $error("column position beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    32'(row_cnt) <= 32'(h_eff) + 32'd1)
    else $error("row position beyond flush row");

  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(wnd))
    else $error("window moved while a result was held");

  a_fwd_follows_read: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1_valid)
    else $error("forwarded line data without an item in the read stage");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int          LATENCY_WAIT = 8;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          CALM_ITEMS   = 340;

  localparam gb3_pkg::cfg_idx_t REG_WIDTH_IDX  =
    gb3_pkg::cfg_idx_t'(gb3_pkg::REG_FRAME_WIDTH);
  localparam gb3_pkg::cfg_idx_t REG_HEIGHT_IDX =
    gb3_pkg::cfg_idx_t'(gb3_pkg::REG_FRAME_HEIGHT);
  // The register file decodes two indexes; the other two must be ignored.
  localparam gb3_pkg::cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam gb3_pkg::cfg_idx_t REG_SPARE_3 = 2'd3;

  typedef struct {
    logic           drain;
    gb3_pkg::chan_t red;
    gb3_pkg::chan_t green;
    gb3_pkg::chan_t blue;
  } px_item_t;

  typedef struct {
    gb3_pkg::chan_t red;
    gb3_pkg::chan_t green;
    gb3_pkg::chan_t blue;
    logic           frame_end;
  } blur_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gb3_pix_in_if  pix_in ();
  gb3_pix_out_if pix_out ();
  gb3_cfg_if     cfg ();

  gaussian_blur_3x3_rgb dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  px_item_t    pixel_q[$];
  blur_px_t    blur_q[$];
  int unsigned items_in_flight = 0;
  int unsigned errors = 0;
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;

  // Shadow of the filter: two line stores, the 3x3 window and the raster position.
  gb3_pkg::pix_t line_upper[gb3_pkg::MAX_WIDTH];
  gb3_pkg::pix_t line_middle[gb3_pkg::MAX_WIDTH];
  gb3_pkg::pix_t win_taps[9];
  int unsigned   pos_col;
  int unsigned   pos_row;
  gb3_pkg::dim_t width_reg;
  gb3_pkg::dim_t height_reg;

  function automatic int unsigned eff_dim(gb3_pkg::dim_t v, int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic gb3_pkg::chan_t blur_chan(int unsigned top, int unsigned lc,
                                               int unsigned rc, int unsigned shift);
    int unsigned   rows[3];
    int unsigned   cols[3];
    int unsigned   wgt[3];
    int unsigned   acc;
    gb3_pkg::pix_t tap;
    rows = '{top, 1, 2};
    cols = '{lc, 1, rc};
    wgt  = '{1, 2, 1};
    acc  = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap = win_taps[rows[i] * 3 + cols[j]];
        acc += wgt[i] * wgt[j] * ((tap >> shift) & 24'hFF);
      end
    end
    return gb3_pkg::chan_t'(acc >> 4);
  endfunction

  task automatic restart_frame();
    pos_col = 0;
    pos_row = 0;
  endtask

  task automatic reset_filter_model();
    for (int i = 0; i < gb3_pkg::MAX_WIDTH; i++) begin
      line_upper[i]  = '0;
      line_middle[i] = '0;
    end
    for (int i = 0; i < 9; i++) win_taps[i] = '0;
    restart_frame();
    width_reg  = gb3_pkg::dim_t'(gb3_pkg::MAX_WIDTH);
    height_reg = gb3_pkg::dim_t'(gb3_pkg::MAX_HEIGHT);
  endtask

  task automatic apply_reg(gb3_pkg::cfg_idx_t idx, gb3_pkg::dim_t val);
    if (idx == REG_WIDTH_IDX) begin
      width_reg = val;
      restart_frame();
    end else if (idx == REG_HEIGHT_IDX) begin
      height_reg = val;
      restart_frame();
    end
  endtask

  // Advances the shadow filter by one accepted transaction and queues the
  // blurred pixel it releases, if any.
  task automatic predict_blur(px_item_t it);
    int unsigned   w, h, col, row, top, lc, rc;
    gb3_pkg::pix_t old_up, old_mid, px;
    logic          emit, last;
    blur_px_t      res;
    w = eff_dim(width_reg, gb3_pkg::MAX_WIDTH);
    h = eff_dim(height_reg, gb3_pkg::MAX_HEIGHT);
    // Drains count only once the frame is complete, pixels only before.
    if (it.drain != (pos_row >= h)) return;
    col = pos_col;
    row = pos_row;
    if (col >= w) col = 0;
    old_up  = line_upper[col];
    old_mid = line_middle[col];
    px = it.drain ? old_mid : {it.red, it.green, it.blue};
    for (int r = 0; r < 3; r++) begin
      win_taps[r * 3]     = win_taps[r * 3 + 1];
      win_taps[r * 3 + 1] = win_taps[r * 3 + 2];
    end
    win_taps[2] = old_up;
    win_taps[5] = old_mid;
    win_taps[8] = px;
    line_upper[col]  = old_mid;
    line_middle[col] = px;
    emit = (row >= 2) || (row == 1 && col >= 1);
    last = (row == h + 1) && (col == 0);
    if (emit) begin
      if (col >= 1) begin
        top = (row >= 2) ? 0 : 1;
        lc  = (col >= 2) ? 0 : 1;
        rc  = 2;
      end else begin
        // The center pixel is the last column of the row two rows back.
        top = (row >= 3) ? 0 : 1;
        lc  = (w >= 2) ? 0 : 1;
        rc  = 1;
      end
      res.red       = blur_chan(top, lc, rc, 16);
      res.green     = blur_chan(top, lc, rc, 8);
      res.blue      = blur_chan(top, lc, rc, 0);
      res.frame_end = last;
      blur_q.push_back(res);
    end
    if (last) begin
      restart_frame();
    end else begin
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      pos_col = col;
      pos_row = row;
    end
  endtask

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  // Pixel driver.
  int       gap_left;
  px_item_t on_wire;

  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        predict_blur(on_wire);
        items_in_flight--;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_in.valid <= 1'b0;
        end else if (!calm && pixel_q.size() != 0 && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 12);
          pix_in.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          on_wire = pixel_q.pop_front();
          pix_in.valid    <= 1'b1;
          pix_in.mode     <= on_wire.drain;
          pix_in.red_in   <= on_wire.red;
          pix_in.green_in <= on_wire.green;
          pix_in.blue_in  <= on_wire.blue;
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  int       stall_left;
  blur_px_t want;

  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (blur_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual r=%h g=%h b=%h end=%b",
                   $time, pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                   pix_out.frame_end);
        end else begin
          want = blur_q.pop_front();
          check_field("red_out", want.red, pix_out.red_out);
          check_field("green_out", want.green, pix_out.green_out);
          check_field("blue_out", want.blue, pix_out.blue_out);
          check_field("frame_end", {7'd0, want.frame_end}, {7'd0, pix_out.frame_end});
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pix_out.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 12);
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** gaussian_blur_3x3_rgb: FAILED **");
      $finish;
    end
  end

  function automatic gb3_pkg::chan_t rand_chan();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return gb3_pkg::chan_t'($urandom_range(0, 255));
  endfunction

  task automatic queue_item(logic drain, gb3_pkg::chan_t r, gb3_pkg::chan_t g,
                            gb3_pkg::chan_t b);
    px_item_t it;
    it.drain = drain;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    items_in_flight++;
    pixel_q.push_back(it);
  endtask

  task automatic queue_random(logic drain);
    queue_item(drain, rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic queue_frame(int unsigned w, int unsigned h);
    for (int unsigned p = 0; p < w * h; p++) queue_random(1'b0);
    for (int unsigned d = 0; d <= w; d++) queue_random(1'b1);
  endtask

  // Holds off until every transaction has been taken and every result has
  // arrived, then lets dropped transactions clear the pipeline.
  task automatic wait_idle();
    do @(posedge clk); while (items_in_flight != 0 || blur_q.size() != 0);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(gb3_pkg::cfg_idx_t idx, gb3_pkg::dim_t val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  initial begin
    int unsigned   random_items;
    int unsigned   w, h, frames, n;
    gb3_pkg::dim_t w_val, h_val;

    pix_in.valid    = 1'b0;
    pix_in.mode     = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_out.ready   = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    reset_filter_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Frame size left at reset: one full row and a little more.
    for (int i = 0; i < gb3_pkg::MAX_WIDTH + 4; i++) queue_random(1'b0);
    wait_idle();

    // 3x3 frame: an early drain that is dropped, extreme colors, a pixel that
    // arrives during the flush and is dropped, then the flush itself.
    write_reg(REG_WIDTH_IDX, gb3_pkg::dim_t'(3));
    write_reg(REG_HEIGHT_IDX, gb3_pkg::dim_t'(3));
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '0);
    queue_item(1'b1, 8'h00, 8'h00, 8'h00);
    for (int k = 0; k < 9; k++) begin
      queue_item(1'b0, (k % 2) ? 8'hFF : 8'h00, (k % 3 == 0) ? 8'hFF : 8'h00,
                 (k < 4) ? 8'hAA : 8'h55);
    end
    queue_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    for (int k = 0; k < 4; k++) queue_item(1'b1, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // One-row frame: the first drain has nothing to release yet.
    write_reg(REG_WIDTH_IDX, gb3_pkg::dim_t'(2));
    write_reg(REG_HEIGHT_IDX, gb3_pkg::dim_t'(1));
    queue_item(1'b0, 8'hFF, 8'h00, 8'hFF);
    queue_item(1'b0, 8'h00, 8'hFF, 8'h00);
    for (int k = 0; k < 3; k++) queue_item(1'b1, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // Zero width acts as one; a single column several rows tall.
    write_reg(REG_WIDTH_IDX, gb3_pkg::dim_t'(0));
    write_reg(REG_HEIGHT_IDX, gb3_pkg::dim_t'(8));
    queue_frame(1, 8);
    wait_idle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       w_val = gb3_pkg::dim_t'(0);
        1:       w_val = gb3_pkg::dim_t'($urandom_range(11, 40));
        default: w_val = gb3_pkg::dim_t'($urandom_range(1, 10));
      endcase
      h_val = gb3_pkg::dim_t'($urandom_range(0, 6));
      if ($urandom_range(0, 1)) begin
        write_reg(REG_WIDTH_IDX, w_val);
        write_reg(REG_HEIGHT_IDX, h_val);
      end else begin
        write_reg(REG_HEIGHT_IDX, h_val);
        write_reg(REG_WIDTH_IDX, w_val);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  gb3_pkg::dim_t'($urandom_range(0, 2047)));
      end
      w = eff_dim(w_val, gb3_pkg::MAX_WIDTH);
      h = eff_dim(h_val, gb3_pkg::MAX_HEIGHT);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(0, 7) == 0) begin
          // Broken sequence: random mix of pixels and drains, then restart.
          n = $urandom_range(0, w * h + w);
          for (int unsigned i = 0; i < n; i++) queue_random(1'($urandom_range(0, 1)));
          break;
        end
        for (int unsigned p = 0; p < w * h; p++) begin
          if ($urandom_range(0, 24) == 0) queue_random(1'b1);
          queue_random(1'b0);
          random_items++;
        end
        for (int unsigned d = 0; d <= w; d++) begin
          if ($urandom_range(0, 11) == 0) queue_random(1'b0);
          queue_random(1'b1);
          random_items++;
        end
      end
      if (random_items >= CALM_ITEMS) calm = 1'b1;
      wait_idle();
    end

    wait_idle();
    repeat (LATENCY_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("** gaussian_blur_3x3_rgb: PASSED **");
    end else begin
      $display("** gaussian_blur_3x3_rgb: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
src/gb3_pkg.sv
src/gb3_if.sv
src/gb3_ram.sv
src/gb3_blur.sv
src/gaussian_blur_3x3_rgb.sv
sim/testbench.sv
